>>> rtl/core/prediction_error_transmit_suppressor_defines.svh
`ifndef PREDICTION_ERROR_TRANSMIT_SUPPRESSOR_DEFINES_SVH
`define PREDICTION_ERROR_TRANSMIT_SUPPRESSOR_DEFINES_SVH

// same-cycle implication
`define PETS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PETS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pets_pkg.sv
`default_nettype none

package pets_pkg;

  localparam int CHANNELS_DEF = 6;
  localparam int MAX_CHANNELS = 6;

  localparam int QUEUE_DEPTH = 4;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LATENCY   = 2'd2;

  localparam logic [15:0] THRESHOLD_RST = 16'd614;
  localparam logic [7:0]  WEIGHT_RST    = 8'd51;
  localparam logic [15:0] LATENCY_RST   = 16'd50;

  typedef struct packed {
    logic signed [15:0] actual_ch0;
    logic signed [15:0] actual_ch1;
    logic signed [15:0] actual_ch2;
    logic signed [15:0] actual_ch3;
    logic signed [15:0] actual_ch4;
    logic signed [15:0] actual_ch5;
    logic signed [15:0] guess_ch0;
    logic signed [15:0] guess_ch1;
    logic signed [15:0] guess_ch2;
    logic signed [15:0] guess_ch3;
    logic signed [15:0] guess_ch4;
    logic signed [15:0] guess_ch5;
  } in_item_t;

  typedef struct packed {
    logic        transmit;
    logic        start_update;
    logic        apply_update;
    logic [15:0] mean_error;
    logic [15:0] smoothed_error;
    logic [15:0] step_index;
  } out_item_t;

  typedef struct packed {
    logic              not_empty;
    logic [QCNT_W-1:0] level;
  } queue_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/pets_front.sv
`default_nettype none

module pets_front #(
  parameter int CHANNELS = pets_pkg::CHANNELS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pets_pkg::in_item_t  in_data,
  input  wire pets_pkg::queue_stat_t q_stat,
  output logic                     push_valid,
  output logic [15:0]              push_mean
);

  localparam int CH_W   = $clog2(CHANNELS);
  localparam int SUM_W  = 16 + CH_W;
  localparam int SHIFT  = SUM_W + CH_W;
  localparam int PROD_W = SUM_W + SHIFT + 1;
  localparam longint RECIP_L = ((longint'(1) << SHIFT) + CHANNELS - 1) / CHANNELS;
  localparam logic [SHIFT:0] RECIP = (SHIFT + 1)'(RECIP_L);

  logic signed [15:0] act [pets_pkg::MAX_CHANNELS];
  logic signed [15:0] gss [pets_pkg::MAX_CHANNELS];
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  logic [PROD_W-1:0]  prod;
  logic [pets_pkg::QCNT_W:0] occ;
  logic               accept;

  assign act[0] = in_data.actual_ch0;
  assign act[1] = in_data.actual_ch1;
  assign act[2] = in_data.actual_ch2;
  assign act[3] = in_data.actual_ch3;
  assign act[4] = in_data.actual_ch4;
  assign act[5] = in_data.actual_ch5;
  assign gss[0] = in_data.guess_ch0;
  assign gss[1] = in_data.guess_ch1;
  assign gss[2] = in_data.guess_ch2;
  assign gss[3] = in_data.guess_ch3;
  assign gss[4] = in_data.guess_ch4;
  assign gss[5] = in_data.guess_ch5;

  always_comb begin
    logic signed [16:0] d;
    logic [16:0]        mag;
    sum = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      d   = 17'(act[i]) - 17'(gss[i]);
      mag = d[16] ? 17'(-d) : 17'(d);
      sum = sum + SUM_W'(mag[15:0]);
    end
  end

  // one queue slot is held for the item in the sum stage
  assign occ      = {1'b0, q_stat.level} + {{pets_pkg::QCNT_W{1'b0}}, s1_valid_r};
  assign in_ready = occ < (pets_pkg::QCNT_W + 1)'(pets_pkg::QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  assign s1_valid_nxt = accept;
  assign sum_nxt      = accept ? sum : sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    sum_r <= sum_nxt;
  end

  // exact floor division by the channel count via reciprocal
  assign prod       = PROD_W'(sum_r) * PROD_W'(RECIP);
  assign push_mean  = prod[SHIFT +: 16];
  assign push_valid = s1_valid_r;

endmodule

`default_nettype wire

>>> rtl/core/pets_queue.sv
`default_nettype none

module pets_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire logic [15:0]           push_mean,
  input  wire logic                  pop,
  output logic [15:0]                head_mean,
  output pets_pkg::queue_stat_t      q_stat
);

  logic [15:0]                   mem [pets_pkg::QUEUE_DEPTH];
  logic [pets_pkg::QIDX_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [pets_pkg::QIDX_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [pets_pkg::QCNT_W-1:0]   count_r, count_nxt;

  localparam logic [pets_pkg::QIDX_W-1:0] LAST = pets_pkg::QIDX_W'(pets_pkg::QUEUE_DEPTH - 1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem[wr_ptr_r] <= push_mean;
    end
  end

  assign head_mean        = mem[rd_ptr_r];
  assign q_stat.not_empty = count_r != '0;
  assign q_stat.level     = count_r;

endmodule

`default_nettype wire

>>> rtl/core/pets_back.sv
`default_nettype none
`include "prediction_error_transmit_suppressor_defines.svh"

module pets_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire pets_pkg::queue_stat_t           q_stat,
  input  wire logic [15:0]                     head_mean,
  output logic                                 pop,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output pets_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [pets_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pets_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [15:0] thr_r, thr_nxt;
  logic [7:0]  wt_r, wt_nxt;
  logic [15:0] lat_r, lat_nxt;

  logic [15:0] avg_r, avg_nxt;
  logic        seen_r, seen_nxt;
  logic        pend_r, pend_nxt;
  logic [15:0] steps_r, steps_nxt;
  logic [15:0] step_r, step_nxt;

  logic                out_valid_r, out_valid_nxt;
  pets_pkg::out_item_t out_data_r, out_data_nxt;

  logic        fire;
  logic        applied, started, tx, pend1;
  logic [15:0] rem1, avg;
  logic [24:0] acc;

  always_comb begin
    thr_nxt = thr_r;
    wt_nxt  = wt_r;
    lat_nxt = lat_r;
    if (cfg_we) begin
      case (cfg_index)
        pets_pkg::CFG_THRESHOLD: thr_nxt = cfg_data;
        pets_pkg::CFG_WEIGHT:    wt_nxt  = cfg_data[7:0];
        pets_pkg::CFG_LATENCY:   lat_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  assign fire = q_stat.not_empty && (!out_valid_r || out_ready);
  assign pop  = fire;

  // countdown runs before this item's decision
  assign applied = pend_r && (steps_r <= 16'd1);
  assign pend1   = pend_r && !applied;
  assign rem1    = applied ? 16'd0 : (pend_r ? steps_r - 16'd1 : steps_r);

  assign acc = ({17'd0, wt_r} * {9'd0, avg_r})
             + ((25'd256 - {17'd0, wt_r}) * {9'd0, head_mean});
  assign avg = acc[23:8];

  assign tx      = (avg > thr_r) || !seen_r;
  assign started = tx && !pend1;

  always_comb begin
    avg_nxt       = avg_r;
    seen_nxt      = seen_r;
    pend_nxt      = pend_r;
    steps_nxt     = steps_r;
    step_nxt      = step_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (fire) begin
      avg_nxt   = avg;
      seen_nxt  = 1'b1;
      pend_nxt  = pend1 || started;
      steps_nxt = started ? lat_r : rem1;
      step_nxt  = step_r + 16'd1;
      out_valid_nxt               = 1'b1;
      out_data_nxt.transmit       = tx;
      out_data_nxt.start_update   = started;
      out_data_nxt.apply_update   = applied;
      out_data_nxt.mean_error     = head_mean;
      out_data_nxt.smoothed_error = avg;
      out_data_nxt.step_index     = step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= pets_pkg::THRESHOLD_RST;
      wt_r        <= pets_pkg::WEIGHT_RST;
      lat_r       <= pets_pkg::LATENCY_RST;
      avg_r       <= '0;
      seen_r      <= 1'b0;
      pend_r      <= 1'b0;
      steps_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      thr_r       <= thr_nxt;
      wt_r        <= wt_nxt;
      lat_r       <= lat_nxt;
      avg_r       <= avg_nxt;
      seen_r      <= seen_nxt;
      pend_r      <= pend_nxt;
      steps_r     <= steps_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PETS_ASSERT_NEXT(a_start_loads, clk, rst_n, fire && started, pend_r && (steps_r == $past(lat_r)), "update start did not load countdown")
  `PETS_ASSERT_SAME(a_idle_count, clk, rst_n, !pend_r, steps_r == 16'd0, "countdown nonzero with no update pending")
  `PETS_ASSERT_NEXT(a_step_inc, clk, rst_n, fire, step_r == 16'($past(step_r) + 16'd1), "step counter skipped")

endmodule

`default_nettype wire

>>> rtl/core/prediction_error_transmit_suppressor.sv
// Prediction error transmit suppressor.
// Input channel (in_valid/in_ready/in_data): one sensor frame per item, six
// measured and six predicted channels in signed Q3.12.
// Output channel (out_valid/out_ready/out_data): one result per item with the
// transmit decision, update start/apply flags, mean error, smoothed error and
// step index.
// Config port (cfg_we/cfg_index/cfg_data): 0 threshold, 1 EWMA weight,
// 2 update latency; other indexes are ignored. Write only while idle.
// Path: an accepted item is registered in the sum stage, goes through the
// reciprocal multiply into a 4-entry queue, and is held in the decision register.
// Throughput: one item per cycle while out_ready is high, set by the
// back-end EWMA/decision loop that carries the average and update countdown.
// Reset (rst_n low, synchronous): registers return to 614/51/50, average,
// counters and flags clear, queue empties; the first item always transmits.
// Receiver stall: the result holds in the output register, the queue fills,
// and in_ready drops once the queue plus the sum stage reach four items.
`default_nettype none

module prediction_error_transmit_suppressor #(
  parameter int CHANNELS = pets_pkg::CHANNELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire pets_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output pets_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [pets_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pets_pkg::CFG_DATA_W-1:0] cfg_data
);

  pets_pkg::queue_stat_t q_stat;
  logic                  push_valid;
  logic [15:0]           push_mean;
  logic                  pop;
  logic [15:0]           head_mean;

  pets_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push_valid(push_valid),
    .push_mean (push_mean)
  );

  pets_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_valid),
    .push_mean(push_mean),
    .pop      (pop),
    .head_mean(head_mean),
    .q_stat   (q_stat)
  );

  pets_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .head_mean(head_mean),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

endmodule

`default_nettype wire
